@@ rtl/penum_pkg.sv @@
// ----------------------------------------------------------------------------
// penum_pkg
// Shared types and constants of the permutation enumerator: sequencer
// states, the order store access request and the sequencer status word.
// ----------------------------------------------------------------------------
`default_nettype none

package penum_pkg;

    // number of positions and width of one position value
    localparam int Lanes = 8;
    localparam int AddrW = 3;
    localparam int ValW  = 4;
    localparam int LenW  = 4;

    localparam logic [LenW-1:0] LenReset = 4'd4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_UNDO_RD,
        ST_UNDO_WA,
        ST_UNDO_WB,
        ST_NEXT_RD,
        ST_NEXT_WA,
        ST_NEXT_WB,
        ST_DONE
    } t_state;

    // one access to the order store: two reads and one write
    typedef struct packed {
        logic             re;
        logic [AddrW-1:0] ra;
        logic [AddrW-1:0] rb;
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [ValW-1:0]  wdata;
    } t_mem_req;

    // sequencer status toward the top level
    typedef struct packed {
        logic            ready;
        logic            done;
        logic            fin;
        logic [LenW-1:0] len;
    } t_ctrl_stat;

endpackage

`default_nettype wire

@@ rtl/penum_order_ram.sv @@
// ----------------------------------------------------------------------------
// penum_order_ram
// Order store: one write port and two registered read ports, used by the
// swap sequencer to exchange two positions.
// ----------------------------------------------------------------------------
`default_nettype none

module penum_order_ram (
    input  wire logic                       i_clk,
    input  wire penum_pkg::t_mem_req        i_req,
    output logic [penum_pkg::ValW-1:0]      o_rd_a,
    output logic [penum_pkg::ValW-1:0]      o_rd_b
);

    logic [penum_pkg::ValW-1:0] r_mem [penum_pkg::Lanes];
    logic [penum_pkg::ValW-1:0] r_rd_a;
    logic [penum_pkg::ValW-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_a <= r_mem[i_req.ra];
            r_rd_b <= r_mem[i_req.rb];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

@@ rtl/penum_ctrl.sv @@
// ----------------------------------------------------------------------------
// penum_ctrl
// Swap sequencer: keeps the choice stack, fills the order store with the
// identity order, and backtracks / descends one swap at a time through the
// shared two-port order store to reach the next leaf.
// ----------------------------------------------------------------------------
`default_nettype none

module penum_ctrl #(
    parameter int MAX_LENGTH = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic                          i_restart,
    input  wire logic [penum_pkg::LenW-1:0]    i_len,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_out_free,
    input  wire logic [penum_pkg::ValW-1:0]    i_rd_a,
    input  wire logic [penum_pkg::ValW-1:0]    i_rd_b,
    output penum_pkg::t_mem_req                o_mem,
    output penum_pkg::t_ctrl_stat              o_stat
);

    localparam logic [penum_pkg::LenW-1:0] MaxLen = penum_pkg::LenW'(MAX_LENGTH);
    localparam logic [penum_pkg::AddrW-1:0] LastLane = penum_pkg::AddrW'(penum_pkg::Lanes - 1);

    penum_pkg::t_state r_state, n_state;

    logic [penum_pkg::LenW-1:0]  r_n;
    logic [penum_pkg::AddrW-1:0] r_k;
    logic [penum_pkg::AddrW-1:0] r_c;
    logic [penum_pkg::AddrW-1:0] r_fill;
    logic [penum_pkg::AddrW-1:0] r_choice [penum_pkg::Lanes];
    logic                        r_started;

    logic [penum_pkg::LenW-1:0]  len_eff;
    logic [penum_pkg::AddrW-1:0] c_inc;
    logic                        c_more;
    logic                        fresh;
    logic                        fin;

    // clamp the configured length to 1..MAX_LENGTH
    always_comb begin
        priority if (i_len == '0) begin
            len_eff = penum_pkg::LenW'(1);
        end else if (i_len > MaxLen) begin
            len_eff = MaxLen;
        end else begin
            len_eff = i_len;
        end
    end

    assign c_inc  = r_c + penum_pkg::AddrW'(1);
    assign c_more = ({1'b0, r_c} + penum_pkg::LenW'(1)) < r_n;
    assign fresh  = i_restart || !r_started;

    // last leaf: every level below the last holds partner n-1
    always_comb begin
        fin = 1'b1;
        for (int i = 0; i < penum_pkg::Lanes - 1; i++) begin
            if ((penum_pkg::LenW'(i + 1) < r_n) &&
                ({1'b0, r_choice[i]} != (r_n - penum_pkg::LenW'(1)))) begin
                fin = 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            penum_pkg::ST_IDLE: begin
                if (i_go) begin
                    n_state = fresh ? penum_pkg::ST_FILL : penum_pkg::ST_UNDO_RD;
                end
            end
            penum_pkg::ST_FILL: begin
                if (r_fill == LastLane) begin
                    n_state = penum_pkg::ST_DONE;
                end
            end
            penum_pkg::ST_UNDO_RD: n_state = penum_pkg::ST_UNDO_WA;
            penum_pkg::ST_UNDO_WA: n_state = penum_pkg::ST_UNDO_WB;
            penum_pkg::ST_UNDO_WB: begin
                priority if (c_more) begin
                    n_state = penum_pkg::ST_NEXT_RD;
                end else if (r_k == '0) begin
                    n_state = penum_pkg::ST_DONE;
                end else begin
                    n_state = penum_pkg::ST_UNDO_RD;
                end
            end
            penum_pkg::ST_NEXT_RD: n_state = penum_pkg::ST_NEXT_WA;
            penum_pkg::ST_NEXT_WA: n_state = penum_pkg::ST_NEXT_WB;
            penum_pkg::ST_NEXT_WB: n_state = penum_pkg::ST_DONE;
            penum_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = penum_pkg::ST_IDLE;
                end
            end
            default: n_state = penum_pkg::ST_IDLE;
        endcase
    end

    // order store requests and status
    always_comb begin
        o_mem       = '0;
        o_stat.ready = (r_state == penum_pkg::ST_IDLE);
        o_stat.done  = (r_state == penum_pkg::ST_DONE);
        o_stat.fin   = fin;
        o_stat.len   = r_n;
        unique case (r_state)
            penum_pkg::ST_FILL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_fill;
                o_mem.wdata = {1'b0, r_fill} + penum_pkg::ValW'(1);
            end
            penum_pkg::ST_UNDO_RD: begin
                o_mem.re = 1'b1;
                o_mem.ra = r_k;
                o_mem.rb = r_choice[r_k];
            end
            penum_pkg::ST_UNDO_WA, penum_pkg::ST_NEXT_WA: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_k;
                o_mem.wdata = i_rd_b;
            end
            penum_pkg::ST_UNDO_WB: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_c;
                o_mem.wdata = i_rd_a;
            end
            penum_pkg::ST_NEXT_RD: begin
                o_mem.re = 1'b1;
                o_mem.ra = r_k;
                o_mem.rb = c_inc;
            end
            penum_pkg::ST_NEXT_WB: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = c_inc;
                o_mem.wdata = i_rd_a;
            end
            default: begin
                o_mem = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= penum_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // level, partner and choice stack updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= penum_pkg::LenW'(1);
            r_k       <= '0;
            r_c       <= '0;
            r_fill    <= '0;
            r_started <= 1'b0;
            for (int i = 0; i < penum_pkg::Lanes; i++) begin
                r_choice[i] <= '0;
            end
        end else begin
            unique case (r_state)
                penum_pkg::ST_IDLE: begin
                    if (i_go) begin
                        r_n    <= len_eff;
                        r_k    <= penum_pkg::AddrW'(len_eff - penum_pkg::LenW'(1));
                        r_fill <= '0;
                        if (fresh) begin
                            for (int i = 0; i < penum_pkg::Lanes; i++) begin
                                r_choice[i] <= penum_pkg::AddrW'(i);
                            end
                        end
                    end
                end
                penum_pkg::ST_FILL: begin
                    r_fill <= r_fill + penum_pkg::AddrW'(1);
                    if (r_fill == LastLane) begin
                        r_started <= 1'b1;
                    end
                end
                penum_pkg::ST_UNDO_RD: begin
                    r_c <= r_choice[r_k];
                end
                penum_pkg::ST_UNDO_WB: begin
                    priority if (c_more) begin
                        // next partner at this level, fresh choices below it
                        r_choice[r_k] <= c_inc;
                        for (int m = 0; m < penum_pkg::Lanes; m++) begin
                            if (penum_pkg::AddrW'(m) > r_k) begin
                                r_choice[m] <= penum_pkg::AddrW'(m);
                            end
                        end
                    end else if (r_k == '0) begin
                        // all swaps undone: order is identity again
                        for (int i = 0; i < penum_pkg::Lanes; i++) begin
                            r_choice[i] <= penum_pkg::AddrW'(i);
                        end
                    end else begin
                        r_k <= r_k - penum_pkg::AddrW'(1);
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
            // a length write restarts the enumeration
            if (i_cfg_we) begin
                r_started <= 1'b0;
            end
        end
    end

    // checks
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (r_state != penum_pkg::ST_IDLE && r_state != penum_pkg::ST_DONE))
        else $error("order store written outside a sequence");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !r_started)
        else $error("length write did not clear started");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == penum_pkg::ST_UNDO_RD) |-> ({1'b0, r_k} < r_n))
        else $error("level beyond length");

    a_go_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == penum_pkg::ST_IDLE && i_go) |=> (r_state != penum_pkg::ST_IDLE))
        else $error("accepted word did not start a sequence");

endmodule

`default_nettype wire

@@ rtl/permutation_enumerator.sv @@
// ----------------------------------------------------------------------------
// permutation_enumerator
// Returns the permutations of 1..n one per request, in the order of the
// recursive swap scheme, with a flag on the last one.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  in       | i_in_valid / o_in_ready  | i_restart
//  out      | o_out_valid / i_out_ready| o_pos_0..o_pos_7, o_is_final
//  cfg      | i_cfg_valid / o_cfg_ready| i_perm_length
//
//  restart or first word: identity fill of all eight positions of the order store
//  next word: one undo swap per level backtracked, then one forward swap,
//  or undo swaps only on the wrap to identity;
//  each swap is one read and two writes on the shared two-port order store
//  one word in work at a time; the next word is taken while a result waits
//  reset is synchronous active low; length resets to 4 and the first word
//  restarts from identity
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_enumerator #(
    parameter int MAX_LENGTH = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_restart,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [penum_pkg::ValW-1:0]       o_pos_0,
    output logic [penum_pkg::ValW-1:0]       o_pos_1,
    output logic [penum_pkg::ValW-1:0]       o_pos_2,
    output logic [penum_pkg::ValW-1:0]       o_pos_3,
    output logic [penum_pkg::ValW-1:0]       o_pos_4,
    output logic [penum_pkg::ValW-1:0]       o_pos_5,
    output logic [penum_pkg::ValW-1:0]       o_pos_6,
    output logic [penum_pkg::ValW-1:0]       o_pos_7,
    output logic                             o_is_final,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [penum_pkg::LenW-1:0]  i_perm_length
);

    logic [penum_pkg::LenW-1:0] r_perm_length;
    logic [penum_pkg::ValW-1:0] r_shadow [penum_pkg::Lanes];
    logic [penum_pkg::ValW-1:0] r_pos    [penum_pkg::Lanes];
    logic                       r_out_valid;
    logic                       r_fin;

    penum_pkg::t_mem_req   mem_req;
    penum_pkg::t_ctrl_stat stat;
    logic [penum_pkg::ValW-1:0] rd_a;
    logic [penum_pkg::ValW-1:0] rd_b;
    logic out_free;
    logic go;
    logic cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_in_ready  = stat.ready;
    assign go          = i_in_valid && stat.ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_length <= penum_pkg::LenReset;
        end else if (cfg_we) begin
            r_perm_length <= i_perm_length;
        end
    end

    penum_ctrl #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_restart  (i_restart),
        .i_len      (r_perm_length),
        .i_cfg_we   (cfg_we),
        .i_out_free (out_free),
        .i_rd_a     (rd_a),
        .i_rd_b     (rd_b),
        .o_mem      (mem_req),
        .o_stat     (stat)
    );

    penum_order_ram u_ram (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // per-position copy of the order store, following its writes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < penum_pkg::Lanes; i++) begin
            if (mem_req.we && (mem_req.waddr == penum_pkg::AddrW'(i))) begin
                r_shadow[i] <= mem_req.wdata;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, unused positions read zero
    always_ff @(posedge i_clk) begin
        if (stat.done && out_free) begin
            for (int i = 0; i < penum_pkg::Lanes; i++) begin
                r_pos[i] <= (penum_pkg::LenW'(i) < stat.len) ? r_shadow[i] : '0;
            end
            r_fin <= stat.fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_0     = r_pos[0];
    assign o_pos_1     = r_pos[1];
    assign o_pos_2     = r_pos[2];
    assign o_pos_3     = r_pos[3];
    assign o_pos_4     = r_pos[4];
    assign o_pos_5     = r_pos[5];
    assign o_pos_6     = r_pos[6];
    assign o_pos_7     = r_pos[7];
    assign o_is_final  = r_fin;

endmodule

`default_nettype wire
